[hw/rtl/csp_pkg.sv]
`timescale 1ns / 1ps
package csp_pkg;

   localparam int SQRT_STAGES = 32;
   localparam int DIV_STAGES  = 31;
   localparam int PRE_STAGES  = 3;
   localparam int MID_STAGES  = SQRT_STAGES + DIV_STAGES;
   localparam int LATENCY     = PRE_STAGES + MID_STAGES + 1;

   localparam logic [2:0] REG_RADIUS      = 3'd0;
   localparam logic [2:0] REG_HALF_HEIGHT = 3'd1;
   localparam logic [2:0] REG_CRUST       = 3'd2;
   localparam logic [2:0] REG_EPS         = 3'd3;

   typedef struct packed {
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } rsp_type;

   // per-request sideband that rides alongside the sqrt and divide
   typedef struct packed {
      logic        neg_x;
      logic        neg_z;
      logic        flag;
      logic [31:0] py;
   } side_type;

endpackage

[hw/rtl/csp_sqrt.sv]
`timescale 1ns / 1ps
module csp_sqrt
   import csp_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] n,
   output logic [31:0] root
);

   logic [63:0] rem_ff  [SQRT_STAGES];
   logic [31:0] root_ff [SQRT_STAGES];

   // one result bit per stage, msb first
   for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
      localparam int K = SQRT_STAGES - 1 - i;
      logic [63:0] rem_p;
      logic [31:0] root_p;
      logic [65:0] trial;
      if (i == 0) begin : g_first
         assign rem_p  = n;
         assign root_p = '0;
      end else begin : g_next
         assign rem_p  = rem_ff[i-1];
         assign root_p = root_ff[i-1];
      end
      assign trial = ({34'd0, root_p} << (K + 1)) + (66'd1 << (2 * K));
      always_ff @(posedge clock) begin
         if (en) begin
            if ({2'b00, rem_p} >= trial) begin
               rem_ff[i]  <= 64'({2'b00, rem_p} - trial);
               root_ff[i] <= root_p | (32'd1 << K);
            end else begin
               rem_ff[i]  <= rem_p;
               root_ff[i] <= root_p;
            end
         end
      end
   end

   assign root = root_ff[SQRT_STAGES-1];

endmodule

[hw/rtl/csp_div.sv]
`timescale 1ns / 1ps
module csp_div
   import csp_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [62:0] num_x,
   input  logic [62:0] num_z,
   input  logic [31:0] den,
   output logic [30:0] quo_x,
   output logic [30:0] quo_z
);

   logic [62:0] rx_ff [DIV_STAGES];
   logic [62:0] rz_ff [DIV_STAGES];
   logic [30:0] qx_ff [DIV_STAGES];
   logic [30:0] qz_ff [DIV_STAGES];
   logic [31:0] d_ff  [DIV_STAGES];

   // restoring divide, both lanes share the divisor
   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
      localparam int K = DIV_STAGES - 1 - i;
      logic [62:0] rx_p, rz_p, dsh;
      logic [30:0] qx_p, qz_p;
      logic [31:0] d_p;
      if (i == 0) begin : g_first
         assign rx_p = num_x;
         assign rz_p = num_z;
         assign qx_p = '0;
         assign qz_p = '0;
         assign d_p  = den;
      end else begin : g_next
         assign rx_p = rx_ff[i-1];
         assign rz_p = rz_ff[i-1];
         assign qx_p = qx_ff[i-1];
         assign qz_p = qz_ff[i-1];
         assign d_p  = d_ff[i-1];
      end
      assign dsh = {31'd0, d_p} << K;
      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[i] <= d_p;
            if (rx_p >= dsh) begin
               rx_ff[i] <= rx_p - dsh;
               qx_ff[i] <= qx_p | (31'd1 << K);
            end else begin
               rx_ff[i] <= rx_p;
               qx_ff[i] <= qx_p;
            end
            if (rz_p >= dsh) begin
               rz_ff[i] <= rz_p - dsh;
               qz_ff[i] <= qz_p | (31'd1 << K);
            end else begin
               rz_ff[i] <= rz_p;
               qz_ff[i] <= qz_p;
            end
         end
      end
   end

   assign quo_x = qx_ff[DIV_STAGES-1];
   assign quo_z = qz_ff[DIV_STAGES-1];

endmodule

[hw/rtl/cylinder_support_point.sv]
`timescale 1ns / 1ps
// Support point of an axis-aligned (y axis) cylinder whose radius and half
// height are the configured sizes each reduced by the crust depth, clamped
// at zero. One request per cycle is taken when the output side keeps up. The
// request passes 67 register stages: three front stages, the 32-step square
// root pipeline (one root bit per stage), the 31-step divide pipeline (one
// quotient bit per stage) and the output register. A stall on the
// result side freezes the whole pipeline. Configuration must only be
// written while no request is in flight.
module cylinder_support_point
   import csp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [30:0] csr_wdata
);

   // configuration registers
   logic [30:0] radius_ff, half_ff, crust_ff;
   logic [15:0] eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 31'd65536;
         half_ff   <= 31'd65536;
         crust_ff  <= '0;
         eps_ff    <= 16'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_RADIUS:      radius_ff <= csr_wdata;
            REG_HALF_HEIGHT: half_ff   <= csr_wdata;
            REG_CRUST:       crust_ff  <= csr_wdata;
            REG_EPS:         eps_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // eroded sizes, clamped at zero
   logic [30:0] r_eff, h_eff;
   logic [31:0] eps_sq;
   assign r_eff  = (radius_ff > crust_ff) ? radius_ff - crust_ff : '0;
   assign h_eff  = (half_ff > crust_ff) ? half_ff - crust_ff : '0;
   assign eps_sq = {16'd0, eps_ff} * {16'd0, eps_ff};

   // global advance: whole pipeline moves unless the output is held
   logic en;
   logic vld_ff [LATENCY];
   assign en        = !vld_ff[LATENCY-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LATENCY; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < LATENCY; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // stage 1: magnitudes, signs, y result
   logic [31:0] ax_ff, az_ff, ay;
   side_type    s1_ff, s2_ff, s3_ff;
   logic [31:0] py_in;
   assign ay = req_data.dir_y[31] ? 32'(-req_data.dir_y) : req_data.dir_y;
   always_comb begin
      if (ay < {16'd0, eps_ff}) py_in = '0;
      else if (req_data.dir_y[31]) py_in = 32'(-{1'b0, h_eff});
      else py_in = {1'b0, h_eff};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff <= req_data.dir_x[31] ? 32'(-req_data.dir_x) : req_data.dir_x;
         az_ff <= req_data.dir_z[31] ? 32'(-req_data.dir_z) : req_data.dir_z;
         s1_ff <= '{neg_x: req_data.dir_x[31], neg_z: req_data.dir_z[31],
                    flag: 1'b0, py: py_in};
      end
   end

   // stage 2: squares and radius products
   logic [63:0] sqx_ff, sqz_ff;
   logic [62:0] px_ff, pz_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff <= 64'(ax_ff) * 64'(ax_ff);
         sqz_ff <= 64'(az_ff) * 64'(az_ff);
         px_ff  <= 63'(ax_ff) * 63'(r_eff);
         pz_ff  <= 63'(az_ff) * 63'(r_eff);
         s2_ff  <= s1_ff;
      end
   end

   // stage 3: horizontal length squared and the short-direction test
   logic [63:0] sum_ff;
   logic [62:0] px3_ff, pz3_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sqx_ff + sqz_ff;
         px3_ff <= px_ff;
         pz3_ff <= pz_ff;
         s3_ff  <= '{neg_x: s2_ff.neg_x, neg_z: s2_ff.neg_z,
                     flag: (sqx_ff + sqz_ff) > {32'd0, eps_sq}, py: s2_ff.py};
      end
   end

   // square root
   logic [31:0] root;
   csp_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .n     (sum_ff),
      .root  (root)
   );

   // products wait for the root
   logic [62:0] pxd_ff [SQRT_STAGES];
   logic [62:0] pzd_ff [SQRT_STAGES];
   always_ff @(posedge clock) begin
      if (en) begin
         pxd_ff[0] <= px3_ff;
         pzd_ff[0] <= pz3_ff;
         for (int i = 1; i < SQRT_STAGES; i++) begin
            pxd_ff[i] <= pxd_ff[i-1];
            pzd_ff[i] <= pzd_ff[i-1];
         end
      end
   end

   // divide by the horizontal length
   logic [30:0] qx, qz;
   csp_div u_div (
      .clock (clock),
      .en    (en),
      .num_x (pxd_ff[SQRT_STAGES-1]),
      .num_z (pzd_ff[SQRT_STAGES-1]),
      .den   (root),
      .quo_x (qx),
      .quo_z (qz)
   );

   // sideband delay across sqrt and divide
   side_type sd_ff [MID_STAGES];
   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[0] <= s3_ff;
         for (int i = 1; i < MID_STAGES; i++) sd_ff[i] <= sd_ff[i-1];
      end
   end

   // output register: apply signs, zero the short horizontal case
   side_type sf;
   rsp_type  rsp_ff;
   assign sf = sd_ff[MID_STAGES-1];
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff.point_y <= sf.py;
         if (sf.flag) begin
            rsp_ff.point_x <= sf.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
            rsp_ff.point_z <= sf.neg_z ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
         end else begin
            rsp_ff.point_x <= '0;
            rsp_ff.point_z <= '0;
         end
      end
   end
   assign rsp_data = rsp_ff;

`ifndef ASSERT_OFF
   a_stall_only_on_hold: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("pipeline stalled without a held result");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("held result changed or dropped");
`endif

endmodule

[tb/tb_cylinder_support_point.sv]
`timescale 1ns / 1ps
module tb_cylinder_support_point;
   import csp_pkg::*;

   // unused register slot, writes there must leave every size alone
   localparam logic [2:0] REG_NONE = 3'd5;
   localparam int CYCLE_LIMIT = 300000;
   localparam logic [30:0] SIZE_MAX = 31'h7fffffff;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [30:0] csr_wdata = '0;

   cylinder_support_point u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the sizes, tracks every write we make
   logic [30:0] radius_q = 31'd65536;
   logic [30:0] half_q   = 31'd65536;
   logic [30:0] crust_q  = 31'd0;
   logic [15:0] eps_q    = 16'd1;

   // per-request note: a hand-typed point, or zero to use the predictor
   typedef struct {
      bit      typed;
      rsp_type point;
   } point_note;

   typedef struct {
      bit          is_cfg;
      logic [2:0]  idx;
      logic [30:0] val;
      req_type     dir;
      bit          typed;
      rsp_type     point;
   } step_row;

   point_note pending_notes[$];
   rsp_type   expected_points[$];
   step_row   script[$];
   int        mismatches = 0;
   int        cycles = 0;
   int        idle_pct = 0;
   int        stall_pct = 0;
   int        hold_cycles = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // integer square root, one result bit per pass
   function automatic logic [63:0] floor_sqrt(logic [63:0] n);
      logic [63:0] root;
      logic [63:0] one_bit;
      root = '0;
      one_bit = 64'h4000_0000_0000_0000;
      while (one_bit > n) one_bit = one_bit >> 2;
      while (one_bit != 0) begin
         if (n >= root + one_bit) begin
            n = n - (root + one_bit);
            root = (root >> 1) + one_bit;
         end else begin
            root = root >> 1;
         end
         one_bit = one_bit >> 2;
      end
      return root;
   endfunction

   function automatic logic [63:0] magnitude(logic signed [31:0] v);
      logic [63:0] wide;
      wide = {{32{v[31]}}, v};
      return v[31] ? 64'd0 - wide : wide;
   endfunction

   // dir * r / s truncated toward zero, then clipped to 32 bits
   function automatic logic [31:0] scale_dir(logic signed [31:0] d, logic [63:0] r,
                                             logic [63:0] s);
      logic [63:0] q;
      q = (magnitude(d) * r) / s;
      if (d[31]) return (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - q);
      return (q > 64'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
   endfunction

   function automatic rsp_type support_point(req_type d);
      rsp_type     p;
      logic [63:0] r, h, e, sum, s;
      r = (radius_q > crust_q) ? 64'(radius_q - crust_q) : 64'd0;
      h = (half_q > crust_q) ? 64'(half_q - crust_q) : 64'd0;
      e = 64'(eps_q);
      sum = magnitude(d.dir_x) * magnitude(d.dir_x) + magnitude(d.dir_z) * magnitude(d.dir_z);
      if (magnitude(d.dir_y) < e) p.point_y = '0;
      else if (d.dir_y[31]) p.point_y = 32'(64'd0 - h);
      else p.point_y = h[31:0];
      if (sum > e * e) begin
         s = floor_sqrt(sum);
         p.point_x = scale_dir(d.dir_x, r, s);
         p.point_z = scale_dir(d.dir_z, r, s);
      end else begin
         p.point_x = '0;
         p.point_z = '0;
      end
      return p;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", field, got, want, cycles);
      mismatches++;
   endtask

   // requests and points are sampled mid-cycle, where everything driven
   // at the rising edge has settled
   always @(negedge clock) begin
      point_note note;
      rsp_type   want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            note = pending_notes.pop_front();
            expected_points.insert(expected_points.size(),
                                   note.typed ? note.point : support_point(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               report_mismatch("unexpected point_x", rsp_data.point_x, '0);
            end else begin
               want = expected_points.pop_front();
               if (rsp_data.point_x !== want.point_x)
                  report_mismatch("point_x", rsp_data.point_x, want.point_x);
               if (rsp_data.point_y !== want.point_y)
                  report_mismatch("point_y", rsp_data.point_y, want.point_y);
               if (rsp_data.point_z !== want.point_z)
                  report_mismatch("point_z", rsp_data.point_z, want.point_z);
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // one request, valid held until taken; gaps only between requests
   task automatic send_dir(req_type d, bit typed, rsp_type point);
      point_note note;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      note.typed = typed;
      note.point = point;
      pending_notes.insert(pending_notes.size(), note);
      req_valid <= 1'b1;
      req_data <= d;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_points.size() != 0 || pending_notes.size() != 0) @(posedge clock);
   endtask

   // sizes change only with the pipeline empty
   task automatic write_reg(logic [2:0] idx, logic [30:0] val);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_RADIUS:      radius_q = val;
         REG_HALF_HEIGHT: half_q = val;
         REG_CRUST:       crust_q = val;
         REG_EPS:         eps_q = val[15:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic req_type dir3(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      req_type d;
      d.dir_x = x;
      d.dir_y = y;
      d.dir_z = z;
      return d;
   endfunction

   function automatic step_row req_row(req_type d, bit typed, rsp_type p);
      step_row row;
      row = '{0, REG_NONE, '0, d, typed, p};
      return row;
   endfunction

   function automatic step_row cfg_row(logic [2:0] idx, logic [30:0] val);
      step_row row;
      row = '{1, idx, val, '0, 0, '0};
      return row;
   endfunction

   function automatic void queue_row(step_row row);
      script.insert(script.size(), row);
   endfunction

   // one component: full range, extremes, or a small value near eps
   function automatic logic [31:0] rand_comp;
      int pick;
      logic [31:0] v;
      pick = $urandom_range(9);
      if (pick < 4) return $urandom;
      if (pick == 4) return 32'h8000_0000;
      if (pick == 5) return 32'h7fff_ffff;
      v = $urandom_range(2 * eps_q + 2);
      return $urandom_range(1) ? v : 32'd0 - v;
   endfunction

   function automatic logic [30:0] rand_size;
      case ($urandom_range(4))
         0: return '0;
         1: return SIZE_MAX;
         2: return 31'd65536;
         3: return 31'($urandom_range(32'h0010_0000));
         default: return 31'($urandom);
      endcase
   endfunction

   initial begin
      rsp_type zero_pt;
      zero_pt = '0;

      // reset sizes: r = h = 1.0, eps = 1
      queue_row(req_row(dir3(32'd65536, 0, 0), 1, '{32'd65536, 0, 0}));
      queue_row(req_row(dir3(0, 32'd65536, 0), 1, '{0, 32'd65536, 0}));
      queue_row(req_row(dir3(0, -32'sd65536, 0), 1, '{0, -32'sd65536, 0}));
      // most negative dir_y
      queue_row(req_row(dir3(0, 32'h8000_0000, 0), 1, '{0, -32'sd65536, 0}));
      queue_row(req_row(dir3(0, 0, -32'sd65536), 1, '{0, 0, -32'sd65536}));
      queue_row(req_row(dir3(32'h7fff_ffff, 0, 0), 1, '{32'd65536, 0, 0}));
      queue_row(req_row(dir3(32'h8000_0000, 0, 0), 1, '{-32'sd65536, 0, 0}));
      queue_row(req_row(dir3(1, 1, 1), 1, '{32'd65536, 32'd65536, 32'd65536}));
      // horizontal length exactly eps, vertical just under it
      queue_row(req_row(dir3(1, 0, 0), 1, zero_pt));
      queue_row(req_row(dir3(32'd300000, -32'sd12345, -32'sd400000), 0, zero_pt));
      // largest sizes
      queue_row(cfg_row(REG_RADIUS, SIZE_MAX));
      queue_row(cfg_row(REG_HALF_HEIGHT, SIZE_MAX));
      queue_row(req_row(dir3(32'h8000_0000, 32'h7fff_ffff, 0), 0, zero_pt));
      queue_row(req_row(dir3(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0, zero_pt));
      // crust eats both sizes
      queue_row(cfg_row(REG_CRUST, SIZE_MAX));
      queue_row(req_row(dir3(5, 5, 5), 1, zero_pt));
      queue_row(cfg_row(REG_CRUST, 31'd1000));
      queue_row(cfg_row(REG_EPS, 31'h0000_ffff));
      queue_row(req_row(dir3(0, 32'h0000_ffff, 32'h0000_fffe), 0, zero_pt));
      queue_row(req_row(dir3(32'h0000_ffff, 32'h0000_fffe, 1), 0, zero_pt));
      // write to an unused slot is dropped
      queue_row(cfg_row(REG_NONE, 31'd123));
      queue_row(req_row(dir3(32'd70000, -32'sd70000, 32'd9), 0, zero_pt));
      queue_row(cfg_row(REG_EPS, 31'd0));
      queue_row(req_row(dir3(0, 0, 0), 0, zero_pt));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].is_cfg) write_reg(script[i].idx, script[i].val);
         else send_dir(script[i].dir, script[i].typed, script[i].point);
      end

      // random phases cycling through idle modes, new sizes each phase
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 47; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 47; end
            default: begin idle_pct = 27; stall_pct = 27; end
         endcase
         write_reg(REG_RADIUS, rand_size());
         write_reg(REG_HALF_HEIGHT, rand_size());
         write_reg(REG_CRUST, ($urandom_range(2) == 0) ? rand_size() : 31'($urandom_range(4096)));
         case ($urandom_range(3))
            0: write_reg(REG_EPS, 31'd0);
            1: write_reg(REG_EPS, 31'h0000_ffff);
            default: write_reg(REG_EPS, 31'($urandom_range(300)));
         endcase
         if (phase == 4) begin
            // long receiver hold-off while requests keep coming
            idle_pct = 0;
            hold_cycles = 400;
         end
         repeat (100) send_dir(dir3(rand_comp(), rand_comp(), rand_comp()), 0, zero_pt);
      end

      req_valid <= 1'b0;
      fork
         drain();
         begin
            repeat (20000) @(posedge clock);
         end
      join_any
      disable fork;
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && expected_points.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
